### hw/rtl/hma_pkg.sv
package hma_pkg;

  localparam int CFG_W  = 6;
  localparam int CFG_AW = 3;
  localparam int APB_DW = 32;
  localparam int IDX_W  = 5;
  localparam int COST_W = 32;
  localparam int KEY_W  = COST_W + 1;
  localparam int VAL_W  = 48;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [KEY_W-1:0] key_t;

  // INF weight for unreachable entries and padding
  localparam val_t INF_VAL   = 48'sh0100_0000_0000;
  localparam val_t SLACK_MAX = 48'sh7FFF_FFFF_FFFF;

  typedef enum logic {
    REG_NUM_OFFICERS = 1'b0,
    REG_NUM_SITES    = 1'b1
  } reg_idx_t;

endpackage

### hw/rtl/hma_in_if.sv
interface hma_in_if;
  import hma_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              unreachable;
  logic              last_entry;

  modport source(output valid, cost, unreachable, last_entry, input ready);
  modport sink(input valid, cost, unreachable, last_entry, output ready);
endinterface

### hw/rtl/hma_out_if.sv
interface hma_out_if;
  import hma_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  officer_index;
  logic [IDX_W-1:0]  site_index;
  logic [COST_W-1:0] pair_cost;
  logic              pair_unreachable;
  logic              last_result;

  modport source(output valid, officer_index, site_index, pair_cost, pair_unreachable,
                 last_result, input ready);
  modport sink(input valid, officer_index, site_index, pair_cost, pair_unreachable,
               last_result, output ready);
endinterface

### hw/rtl/hungarian_min_cost_assignment_top.sv
// channel  dir  handshake       payload
// in_if    in   valid/ready     cost[31:0], unreachable, last_entry
// out_if   out  valid/ready     officer_index[4:0], site_index[4:0], pair_cost[31:0],
//                               pair_unreachable, last_result
// cfg_*    in   APB             num_officers at 0x0, num_sites at 0x4 (6 bits each)
//
// Matrix entries load at one item per cycle into the cost memory while in_if.ready
// is high (it is low outside loading and during a num_sites write and re-placement).
// The item flagged last_entry starts the solve: clearing, then per row a slack init
// and tree steps (one column memory access per cycle for the slack scan and the
// potential update), then the augment steps. Gathering follows, and each emitted item
// takes a scan of the result buffer.
// A write to num_sites re-derives the load row/column from the load position with a
// restoring divider: one quotient bit per cycle; in_if.ready is low meanwhile.
// Reset: synchronous, active low; clears control state only. The cost memory has no
// clearing pass: entries read before being written are undefined.
// Stalls: a finished item waits in the output register while the next item is
// scanned; emission stops only when the output register is still full.
module hungarian_min_cost_assignment_top #(
  parameter int MAX_DIM   = 32,
  parameter int COST_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hma_in_if.sink                        in_if,
  hma_out_if.source                     out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hma_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [hma_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [hma_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import hma_pkg::*;

  localparam int DW    = $clog2(MAX_DIM + 1);      // column/row index 0..MAX_DIM
  localparam int IW    = $clog2(MAX_DIM);          // real index 0..MAX_DIM-1
  localparam int DEPTH = MAX_DIM + 1;
  localparam int NCELL = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(NCELL);
  localparam int PW    = $clog2(NCELL + 1);
  localparam int CNTW  = $clog2(PW + 1);
  localparam logic [COST_W-1:0] COST_MASK =
    (COST_BITS >= COST_W) ? {COST_W{1'b1}} : COST_W'((64'd1 << COST_BITS) - 64'd1);

  typedef struct packed {
    val_t          v;     // column potential
    val_t          mn;    // minimum slack
    logic [DW-1:0] p;     // matched row (0 = none)
    logic [DW-1:0] way;   // back-link
    logic          used;
  } col_t;

  typedef struct packed {
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    key_t          key;
  } buf_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_DIV, ST_CLR, ST_RINIT, ST_PICK, ST_PICK_W, ST_PICK_U, ST_SCAN,
    ST_UPD, ST_AUG_RD, ST_AUG_LD, ST_AUG, ST_GATHER, ST_EMIT_SCAN, ST_EMIT_OUT
  } state_t;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return DW'(1);
    if (int'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  function automatic val_t key_val(input key_t k);
    return k[KEY_W-1] ? INF_VAL : val_t'(k[COST_W-1:0]);
  endfunction

  // ---------------------------------------------------------------- state
  state_t            state_r;
  logic [CFG_W-1:0]  no_cfg_r, ns_cfg_r;
  logic [DW-1:0]     no_eff, ns_eff;
  logic [PW-1:0]     pos_r, row_r, div_q_r;
  logic [DW-1:0]     col_r;
  logic [DW:0]       rem_r, div_sh, div_rem;
  logic              div_ge;
  logic [CNTW-1:0]   div_cnt_r;

  logic [DW-1:0]     n_r, no_s_r, ns_s_r, i_r, j0_r, j1_r, i0_r;
  val_t              u_r, delta_r;
  logic [DW-1:0]     k_r, k_end;
  logic              iss_r;
  logic              s1_v_r, s1_inf_r, s2_v_r, s2_v_nxt;
  logic [DW-1:0]     s1_j_r, s2_j_r, s2_p_r;
  col_t              s2_word_r;
  val_t              s2_cur_r;
  logic [IW-1:0]     s2_brow_r, s2_bcol_r;
  col_t              aug_w_r;
  logic [DW:0]       guard_r, guard_n;

  logic [DW-1:0]     cnt_r, emit_cnt_r;
  logic              first_r, best_v_r;
  buf_t              best_r;
  key_t              last_key_r;
  logic [IW-1:0]     last_k_r, best_k_r;
  logic              emit_gt;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_off_r, out_site_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_unr_r, out_last_r;

  // memories
  col_t              col_mem [DEPTH];
  val_t              row_mem [DEPTH];
  key_t              cost_mem [NCELL];
  buf_t              buf_mem [MAX_DIM];
  col_t              col_rd_r;
  val_t              row_rd_r;
  key_t              cost_rd_r;
  buf_t              buf_rd_r;

  logic [DW-1:0]     col_ra, col_wa, row_ra, row_wa;
  logic              col_we, row_we, cost_we, buf_we;
  col_t              col_wd;
  val_t              row_wd;
  logic [AW-1:0]     cost_ra, cost_wa;
  key_t              cost_wd;
  logic [IW-1:0]     buf_ra, buf_wa;
  buf_t              buf_wd;

  logic              cfg_wr, ns_wr, in_acc, ld_store;
  reg_idx_t          cfg_sel;
  val_t              scan_cur, scan_val;
  col_t              scan_upd;
  logic              scan_better, gath_ok, sweep_done, emit_load, emit_last;

  // ---------------------------------------------------------------- config port
  assign cfg_sel    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign ns_wr      = cfg_wr && (cfg_sel == REG_NUM_SITES);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_sel == REG_NUM_SITES) ? APB_DW'(ns_cfg_r) : APB_DW'(no_cfg_r);

  assign no_eff = clamp_dim(no_cfg_r);
  assign ns_eff = clamp_dim(ns_cfg_r);

  assign in_if.ready = (state_r == ST_LOAD) && !ns_wr;
  assign in_acc      = in_if.valid && in_if.ready;
  assign ld_store    = in_acc && (row_r < PW'(no_eff));

  // restoring divider step: load position / num_sites
  assign div_sh  = {rem_r[DW-1:0], div_q_r[PW-1]};
  assign div_ge  = div_sh >= (DW + 1)'(ns_eff);
  assign div_rem = div_ge ? div_sh - (DW + 1)'(ns_eff) : div_sh;

  assign sweep_done = !iss_r && !s1_v_r && !s2_v_r;
  assign guard_n    = guard_r + 1'b1;

  // scan: slack of the current column against row i0
  assign scan_val = s1_inf_r ? INF_VAL : key_val(cost_rd_r);
  assign scan_cur = scan_val - u_r - col_rd_r.v;

  always_comb begin
    scan_upd = s2_word_r;
    if (!s2_word_r.used && ($signed(s2_cur_r) < $signed(s2_word_r.mn))) begin
      scan_upd.mn  = s2_cur_r;
      scan_upd.way = j0_r;
    end
  end
  assign scan_better = !s2_word_r.used && ($signed(scan_upd.mn) < $signed(delta_r));

  assign gath_ok = (col_rd_r.p != '0) && (col_rd_r.p <= no_s_r) && (s1_j_r <= ns_s_r);

  assign emit_gt = first_r || (buf_rd_r.key > last_key_r) ||
                   ((buf_rd_r.key == last_key_r) && (IW'(s1_j_r) > last_k_r));
  assign emit_load = (state_r == ST_EMIT_OUT) && (!out_valid_r || out_if.ready);
  assign emit_last = (emit_cnt_r + 1'b1) == cnt_r;

  always_comb begin
    unique case (state_r)
      ST_EMIT_SCAN: k_end = cnt_r - 1'b1;
      default:      k_end = n_r;
    endcase
  end

  // ---------------------------------------------------------------- memory ports
  always_comb begin
    col_ra   = k_r;
    col_we   = 1'b0;
    col_wa   = s1_j_r;
    col_wd   = col_rd_r;
    row_ra   = col_rd_r.p;
    row_we   = 1'b0;
    row_wa   = s2_p_r;
    row_wd   = row_rd_r + delta_r;
    cost_ra  = cell_addr(IW'(i0_r - 1'b1), IW'(k_r - 1'b1));
    cost_we  = ld_store;
    cost_wa  = cell_addr(IW'(row_r), IW'(col_r));
    cost_wd  = in_if.unreachable ? {1'b1, {COST_W{1'b0}}}
                                 : {1'b0, in_if.cost & COST_MASK};
    buf_ra   = IW'(k_r);
    buf_we   = 1'b0;
    buf_wa   = IW'(cnt_r);
    buf_wd   = '{row: s2_brow_r, col: s2_bcol_r, key: cost_rd_r};
    s2_v_nxt = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        col_we = 1'b1;
        col_wa = k_r;
        col_wd = '0;
        row_we = 1'b1;
        row_wa = k_r;
        row_wd = '0;
      end
      ST_RINIT: begin
        col_we    = s1_v_r;
        col_wd.mn = SLACK_MAX;
        col_wd.used = 1'b0;
        if (s1_j_r == '0) col_wd.p = i_r;
      end
      ST_PICK: col_ra = j0_r;
      ST_PICK_W: begin
        if (col_rd_r.p == '0) begin
          col_ra = col_rd_r.way;
        end else begin
          col_we      = 1'b1;
          col_wa      = j0_r;
          col_wd.used = 1'b1;
        end
      end
      ST_SCAN: begin
        s2_v_nxt = s1_v_r;
        col_we   = s2_v_r;
        col_wa   = s2_j_r;
        col_wd   = scan_upd;
      end
      ST_UPD: begin
        col_we   = s1_v_r;
        s2_v_nxt = s1_v_r && col_rd_r.used;
        if (col_rd_r.used) col_wd.v = col_rd_r.v - delta_r;
        else col_wd.mn = col_rd_r.mn - delta_r;
        row_we = s2_v_r;
      end
      ST_AUG_RD: col_ra = j0_r;
      ST_AUG_LD: col_ra = col_rd_r.way;
      ST_AUG: begin
        col_ra   = col_rd_r.way;
        col_we   = 1'b1;
        col_wa   = j0_r;
        col_wd   = aug_w_r;
        col_wd.p = col_rd_r.p;
      end
      ST_GATHER: begin
        cost_ra  = cell_addr(IW'(col_rd_r.p - 1'b1), IW'(s1_j_r - 1'b1));
        s2_v_nxt = s1_v_r && gath_ok;
        buf_we   = s2_v_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd_r <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    row_rd_r <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_rd_r <= cost_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    buf_rd_r <= buf_mem[buf_ra];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      no_cfg_r    <= CFG_W'(1);
      ns_cfg_r    <= CFG_W'(1);
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      iss_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_sel == REG_NUM_SITES) ns_cfg_r <= cfg_pwdata[CFG_W-1:0];
        else no_cfg_r <= cfg_pwdata[CFG_W-1:0];
      end

      // sweep pipeline: issue stage, then read data stage, then write stage
      s2_v_r    <= s2_v_nxt;
      s2_j_r    <= s1_j_r;
      s2_word_r <= col_rd_r;
      s2_cur_r  <= scan_cur;
      s2_p_r    <= col_rd_r.p;
      s2_brow_r <= IW'(col_rd_r.p - 1'b1);
      s2_bcol_r <= IW'(s1_j_r - 1'b1);
      s1_inf_r  <= (i0_r > no_s_r) || (k_r > ns_s_r);
      if (iss_r) begin
        s1_v_r <= 1'b1;
        s1_j_r <= k_r;
        if (k_r == k_end) iss_r <= 1'b0;
        else k_r <= k_r + 1'b1;
      end else begin
        s1_v_r <= 1'b0;
      end

      if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_LOAD: begin
          if (ns_wr) begin
            // re-place the load position under the new row length
            state_r   <= ST_DIV;
            rem_r     <= '0;
            div_q_r   <= pos_r;
            div_cnt_r <= '0;
          end else if (in_acc) begin
            if (ld_store) begin
              pos_r <= pos_r + 1'b1;
              if (col_r + 1'b1 == ns_eff) begin
                col_r <= '0;
                row_r <= row_r + 1'b1;
              end else begin
                col_r <= col_r + 1'b1;
              end
            end
            if (in_if.last_entry) begin
              no_s_r  <= no_eff;
              ns_s_r  <= ns_eff;
              n_r     <= (no_eff > ns_eff) ? no_eff : ns_eff;
              pos_r   <= '0;
              row_r   <= '0;
              col_r   <= '0;
              k_r     <= '0;
              state_r <= ST_CLR;
            end
          end
        end
        ST_DIV: begin
          if (ns_wr) begin
            rem_r     <= '0;
            div_q_r   <= pos_r;
            div_cnt_r <= '0;
          end else begin
            rem_r     <= div_rem;
            div_q_r   <= {div_q_r[PW-2:0], div_ge};
            div_cnt_r <= div_cnt_r + 1'b1;
            if (div_cnt_r == CNTW'(PW - 1)) begin
              row_r   <= {div_q_r[PW-2:0], div_ge};
              col_r   <= DW'(div_rem);
              state_r <= ST_LOAD;
            end
          end
        end
        ST_CLR: begin
          if (k_r == n_r) begin
            i_r     <= DW'(1);
            k_r     <= '0;
            iss_r   <= 1'b1;
            state_r <= ST_RINIT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_RINIT: begin
          if (sweep_done) begin
            j0_r    <= '0;
            state_r <= ST_PICK;
          end
        end
        ST_PICK: state_r <= ST_PICK_W;
        ST_PICK_W: begin
          if (col_rd_r.p == '0) begin
            // reached a free column: walk the back-links
            aug_w_r <= col_rd_r;
            guard_r <= '0;
            state_r <= ST_AUG;
          end else begin
            i0_r    <= col_rd_r.p;
            state_r <= ST_PICK_U;
          end
        end
        ST_PICK_U: begin
          u_r     <= row_rd_r;
          delta_r <= SLACK_MAX;
          j1_r    <= '0;
          k_r     <= DW'(1);
          iss_r   <= 1'b1;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (s2_v_r && scan_better) begin
            delta_r <= scan_upd.mn;
            j1_r    <= s2_j_r;
          end
          if (sweep_done) begin
            if (j1_r == '0) begin
              state_r <= ST_AUG_RD;
            end else begin
              k_r     <= '0;
              iss_r   <= 1'b1;
              state_r <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          if (sweep_done) begin
            j0_r    <= j1_r;
            state_r <= ST_PICK;
          end
        end
        ST_AUG_RD: state_r <= ST_AUG_LD;
        ST_AUG_LD: begin
          aug_w_r <= col_rd_r;
          guard_r <= '0;
          state_r <= ST_AUG;
        end
        ST_AUG: begin
          guard_r <= guard_n;
          j0_r    <= aug_w_r.way;
          aug_w_r <= col_rd_r;
          if ((aug_w_r.way == '0) || (guard_n > (DW + 1)'(n_r))) begin
            if (i_r == n_r) begin
              cnt_r   <= '0;
              k_r     <= DW'(1);
              iss_r   <= 1'b1;
              state_r <= ST_GATHER;
            end else begin
              i_r     <= i_r + 1'b1;
              k_r     <= '0;
              iss_r   <= 1'b1;
              state_r <= ST_RINIT;
            end
          end
        end
        ST_GATHER: begin
          if (s2_v_r) cnt_r <= cnt_r + 1'b1;
          if (sweep_done) begin
            first_r    <= 1'b1;
            emit_cnt_r <= '0;
            best_v_r   <= 1'b0;
            k_r        <= '0;
            iss_r      <= 1'b1;
            state_r    <= ST_EMIT_SCAN;
          end
        end
        ST_EMIT_SCAN: begin
          // next item: smallest (cost, site order) above the one last emitted
          if (s1_v_r && emit_gt && (!best_v_r || (buf_rd_r.key < best_r.key))) begin
            best_r   <= buf_rd_r;
            best_k_r <= IW'(s1_j_r);
            best_v_r <= 1'b1;
          end
          if (sweep_done) state_r <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (emit_load) begin
            out_valid_r <= 1'b1;
            out_off_r   <= IDX_W'(best_r.row);
            out_site_r  <= IDX_W'(best_r.col);
            out_cost_r  <= best_r.key[COST_W-1:0];
            out_unr_r   <= best_r.key[KEY_W-1];
            out_last_r  <= emit_last;
            last_key_r  <= best_r.key;
            last_k_r    <= best_k_r;
            first_r     <= 1'b0;
            emit_cnt_r  <= emit_cnt_r + 1'b1;
            if (emit_last) begin
              state_r <= ST_LOAD;
            end else begin
              best_v_r <= 1'b0;
              k_r      <= '0;
              iss_r    <= 1'b1;
              state_r  <= ST_EMIT_SCAN;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.officer_index    = out_off_r;
  assign out_if.site_index       = out_site_r;
  assign out_if.pair_cost        = out_cost_r;
  assign out_if.pair_unreachable = out_unr_r;
  assign out_if.last_result      = out_last_r;

  // ---------------------------------------------------------------- checks
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_OUT) |-> (emit_cnt_r < cnt_r))
    else $error("emission count passed the gathered pair count");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_SCAN) |-> (cnt_r != '0))
    else $error("emission started with no gathered pairs");

  a_scan_delta: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (j1_r != '0)) |-> ($signed(delta_r) < $signed(SLACK_MAX)))
    else $error("chosen column without a reduced slack");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (!s1_v_r && !s2_v_r && !iss_r))
    else $error("sweep pipeline busy while loading");

endmodule

### tb/tb_top.sv
module tb_top;
  import hma_pkg::*;

  localparam int DIM       = 32;
  localparam int WDOG_MAX  = 600000;
  localparam int SETTLE    = 80;
  localparam longint INF_W = 64'd1 << 40;

  // one matrix entry as offered on the input channel
  typedef struct {
    logic [COST_W-1:0] cost;
    bit                unr;
    bit                last;
    bit                drain_first;  // wait for every pending pair before offering
  } entry_t;

  // one matched officer/site pair
  typedef struct {
    logic [IDX_W-1:0]  officer;
    logic [IDX_W-1:0]  site;
    logic [COST_W-1:0] cost;
    bit                unr;
    bit                last;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  hma_in_if  in_if ();
  hma_out_if out_if ();

  hungarian_min_cost_assignment_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Assignment predictor: own copy of the cost memory, load position and registers
  // ---------------------------------------------------------------------------
  longint unsigned cost_mem [DIM*DIM];
  int              load_pos;
  bit [CFG_W-1:0]  num_officers_q = 1;
  bit [CFG_W-1:0]  num_sites_q    = 1;
  pair_t           pending_pairs [$];

  int n_solves;
  int n_pairs_seen;
  int n_unr_pairs;
  int n_errors;

  function automatic int clamp_dim(bit [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic longint padded_cost(int r, int c, int no, int ns);
    if (r < no && c < ns) return longint'(cost_mem[r*DIM + c]);
    return INF_W;
  endfunction

  // Hungarian method with row/column potentials; push the matched real pairs
  // sorted by cost, lower site first on ties.
  function automatic void solve_assignment();
    int     no, ns, n, i0, j0, j1, guard, cnt, k;
    longint u [DIM+1];
    longint v [DIM+1];
    longint minv [DIM+1];
    int     match [DIM+1];
    int     way [DIM+1];
    bit     used [DIM+1];
    longint delta, cur;
    longint unsigned pv [DIM];
    int     pr [DIM];
    int     pc [DIM];
    pair_t  p;
    no = clamp_dim(num_officers_q);
    ns = clamp_dim(num_sites_q);
    n  = (no > ns) ? no : ns;
    cnt = 0;
    for (int j = 0; j <= DIM; j++) begin
      u[j] = 0; v[j] = 0; match[j] = 0; way[j] = 0;
    end
    for (int i = 1; i <= n; i++) begin
      j0 = 0;
      match[0] = i;
      for (int j = 0; j <= n; j++) begin
        minv[j] = SLACK_MAX;
        used[j] = 1'b0;
      end
      do begin
        i0 = match[j0];
        j1 = 0;
        delta = SLACK_MAX;
        used[j0] = 1'b1;
        for (int j = 1; j <= n; j++) begin
          if (!used[j]) begin
            cur = padded_cost(i0-1, j-1, no, ns) - u[i0] - v[j];
            if (cur < minv[j]) begin
              minv[j] = cur;
              way[j] = j0;
            end
            if (minv[j] < delta) begin
              delta = minv[j];
              j1 = j;
            end
          end
        end
        if (j1 == 0) break;
        for (int j = 0; j <= n; j++) begin
          if (used[j]) begin
            u[match[j]] += delta;
            v[j] -= delta;
          end else begin
            minv[j] -= delta;
          end
        end
        j0 = j1;
      end while (match[j0] != 0);
      guard = 0;
      do begin
        j1 = way[j0];
        match[j0] = match[j1];
        j0 = j1;
        guard++;
      end while (j0 != 0 && guard <= n);
    end
    for (int j = 1; j <= n; j++) begin
      if (match[j] > 0 && match[j]-1 < no && j-1 < ns) begin
        k = cnt;
        while (k > 0 && pv[k-1] > cost_mem[(match[j]-1)*DIM + j-1]) begin
          pv[k] = pv[k-1]; pr[k] = pr[k-1]; pc[k] = pc[k-1];
          k--;
        end
        pv[k] = cost_mem[(match[j]-1)*DIM + j-1];
        pr[k] = match[j] - 1;
        pc[k] = j - 1;
        cnt++;
      end
    end
    for (int m = 0; m < cnt; m++) begin
      p.officer = pr[m][IDX_W-1:0];
      p.site    = pc[m][IDX_W-1:0];
      p.unr     = (pv[m] >= INF_W);
      p.cost    = p.unr ? '0 : pv[m][COST_W-1:0];
      p.last    = (m == cnt-1);
      pending_pairs.push_back(p);
    end
    n_solves++;
  endfunction

  // place one accepted entry; a flagged entry starts the solve
  function automatic void load_entry(entry_t e);
    int no, ns, r, c;
    no = clamp_dim(num_officers_q);
    ns = clamp_dim(num_sites_q);
    r = load_pos / ns;
    c = load_pos % ns;
    if (r < no) begin
      cost_mem[r*DIM + c] = e.unr ? INF_W : longint'(e.cost);
      load_pos++;
    end
    if (e.last) begin
      solve_assignment();
      load_pos = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: sender 26% / receiver 80%, then swapped, then no idling
  // ---------------------------------------------------------------------------
  int n_in_accepted;
  int n_out_accepted;

  function automatic int send_idle_pct();
    if (n_in_accepted < 90) return 26;
    if (n_in_accepted < 180) return 80;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_in_accepted < 90) return 80;
    if (n_in_accepted < 180) return 26;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer entries from the queue, hold each until accepted
  // ---------------------------------------------------------------------------
  entry_t entry_queue [$];

  always @(posedge clk) begin
    entry_t e;
    bit     offer;
    bit     taken;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      taken = in_if.valid && in_if.ready;
      if (taken) begin
        e = entry_queue.pop_front();
        load_entry(e);
        n_in_accepted++;
      end
      offer = in_if.valid && !taken;  // hold an entry not yet taken
      if (!offer && entry_queue.size() > 0) begin
        if (entry_queue[0].drain_first && pending_pairs.size() > 0)
          offer = 1'b0;  // pause until every pair has come back
        else
          offer = ($urandom_range(99) >= send_idle_pct());
      end
      in_if.valid <= offer;
      if (offer && entry_queue.size() > 0) begin
        in_if.cost        <= entry_queue[0].cost;
        in_if.unreachable <= entry_queue[0].unr;
        in_if.last_entry  <= entry_queue[0].last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each pair with the oldest prediction; random and long stalls
  // ---------------------------------------------------------------------------
  bit want_holdoff;
  int holdoff_cnt;

  always @(posedge clk) begin
    pair_t exp_p;
    bit    bad;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_out_accepted++;
        if (pending_pairs.size() == 0) begin
          $display("%0t: unexpected pair officer=%0d site=%0d cost=%0d unr=%0b last=%0b",
                   $time, out_if.officer_index, out_if.site_index, out_if.pair_cost,
                   out_if.pair_unreachable, out_if.last_result);
          n_errors++;
        end else begin
          exp_p = pending_pairs.pop_front();
          bad = 1'b0;
          if (out_if.officer_index !== exp_p.officer) bad = 1'b1;
          if (out_if.site_index !== exp_p.site) bad = 1'b1;
          if (out_if.pair_cost !== exp_p.cost) bad = 1'b1;
          if (out_if.pair_unreachable !== exp_p.unr) bad = 1'b1;
          if (out_if.last_result !== exp_p.last) bad = 1'b1;
          if (bad) begin
            $display("%0t: mismatch expected off=%0d site=%0d cost=%0d unr=%0b last=%0b",
                     $time, exp_p.officer, exp_p.site, exp_p.cost, exp_p.unr, exp_p.last);
            $display("%0t:          actual   off=%0d site=%0d cost=%0d unr=%0b last=%0b",
                     $time, out_if.officer_index, out_if.site_index, out_if.pair_cost,
                     out_if.pair_unreachable, out_if.last_result);
            n_errors++;
          end
          n_pairs_seen++;
          if (exp_p.unr) n_unr_pairs++;
        end
      end
      // a long hold-off lets the block back up into its input
      if (want_holdoff && out_if.valid) begin
        want_holdoff <= 1'b0;
        holdoff_cnt  <= 500;
        out_if.ready <= 1'b0;
      end else if (holdoff_cnt > 0) begin
        holdoff_cnt  <= holdoff_cnt - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("%0t: timeout, %0d pairs still outstanding", $time, pending_pairs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation: track where each entry lands so that no solve ever reads
  // a cost memory position that was never written
  // ---------------------------------------------------------------------------
  int gen_no = 1;
  int gen_ns = 1;
  int gen_pos;
  bit gen_written [DIM*DIM];
  int gen_count;

  function automatic void push_entry(logic [COST_W-1:0] cost, bit unr, bit last,
                                     bit drain_first);
    entry_t e;
    int r, c;
    r = gen_pos / gen_ns;
    c = gen_pos % gen_ns;
    if (r < gen_no) begin
      gen_written[r*DIM + c] = 1'b1;
      gen_pos++;
    end
    if (last) gen_pos = 0;
    e.cost = cost;
    e.unr = unr;
    e.last = last;
    e.drain_first = drain_first;
    entry_queue.push_back(e);
    gen_count++;
  endfunction

  function automatic bit all_written();
    for (int r = 0; r < gen_no; r++)
      for (int c = 0; c < gen_ns; c++)
        if (!gen_written[r*DIM + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [COST_W-1:0] rand_cost();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom_range(7);       // many ties
    if (sel < 36) return '1;
    if (sel < 40) return '0;
    return $urandom;
  endfunction

  // style: 0 full matrix, 1 early last entry, 2 extra entries past the matrix
  function automatic void push_matrix(int style, bit drain_first);
    int total, stop;
    total = gen_no * gen_ns;
    stop = total;
    if (style == 1 && all_written()) stop = $urandom_range(1, total);
    if (style == 2) stop = total + $urandom_range(1, 3);
    for (int k = 0; k < stop; k++)
      push_entry(rand_cost(), ($urandom_range(99) < 12), (k == stop-1),
                 drain_first && (k == 0));
  endfunction

  task automatic cfg_write(reg_idx_t idx, bit [CFG_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= APB_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_NUM_OFFICERS) begin
      num_officers_q = val;
      gen_no = clamp_dim(val);
    end else begin
      num_sites_q = val;
      gen_ns = clamp_dim(val);
    end
  endtask

  // let every queued entry go in and every pair come out, then let the block settle
  task automatic wait_drained();
    while (entry_queue.size() > 0 || pending_pairs.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_dims(bit [CFG_W-1:0] no, bit [CFG_W-1:0] ns);
    wait_drained();
    cfg_write(REG_NUM_OFFICERS, no);
    cfg_write(REG_NUM_SITES, ns);
  endtask

  initial begin
    bit [CFG_W-1:0] rno, rns;
    int sel;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_if.valid       = 1'b0;
    in_if.cost        = '0;
    in_if.unreachable = 1'b0;
    in_if.last_entry  = 1'b0;
    out_if.ready      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 1x1 at reset values, cost extremes and an unreachable entry
    push_entry('0, 1'b0, 1'b1, 1'b0);
    push_entry('1, 1'b0, 1'b1, 1'b0);
    push_entry(32'h1234_5678, 1'b1, 1'b1, 1'b0);
    // zero officers clamps to one, 63 sites clamps to the full width
    set_dims(6'd0, 6'd63);
    for (int k = 0; k < DIM; k++)
      push_entry((k % 2) ? '1 : COST_W'(DIM - k), (k == 5), (k == DIM-1), 1'b0);
    // 3x2: all unreachable, then an early last entry over stale entries,
    // then extra entries past the matrix
    set_dims(6'd3, 6'd2);
    for (int k = 0; k < 6; k++) push_entry($urandom, 1'b1, (k == 5), 1'b0);
    push_entry(32'd5, 1'b0, 1'b0, 1'b0);
    push_entry(32'd5, 1'b0, 1'b1, 1'b0);
    for (int k = 0; k < 8; k++) push_entry(COST_W'(k), 1'b0, (k == 7), 1'b0);

    // random phases
    while (gen_count < 330) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        rno = $urandom_range(0, 6);
        rns = $urandom_range(1, 6);
      end else if (sel < 92) begin
        rno = ($urandom_range(1)) ? 6'd32 : 6'd63;
        rns = $urandom_range(1, 2);
      end else begin
        rno = $urandom_range(1, 2);
        rns = ($urandom_range(1)) ? 6'd32 : 6'd45;
      end
      set_dims(rno, rns);
      if (gen_count > 80 && gen_count < 200 && !want_holdoff && holdoff_cnt == 0 &&
          n_out_accepted < 1000) begin
        want_holdoff = 1'b1;
      end
      push_matrix(0, 1'b0);
      for (int m = 0; m < 3; m++) begin
        sel = $urandom_range(99);
        push_matrix((sel < 60) ? 0 : (sel < 80) ? 1 : 2, (m == 1));
      end
      // occasional noise: one more full matrix under the same sizes; like every
      // matrix here it ends on a last entry, so the next phase starts clean
      if ($urandom_range(3) == 0) push_matrix(0, 1'b0);
    end

    wait_drained();
    $display("Ran %0d entries through %0d solves; checked %0d pairs (%0d unreachable).",
             n_in_accepted, n_solves, n_pairs_seen, n_unr_pairs);
    $display("Covered clamped sizes, stale and extra entries, long output stalls.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/hma_pkg.sv
hw/rtl/hma_in_if.sv
hw/rtl/hma_out_if.sv
hw/rtl/hungarian_min_cost_assignment_top.sv
tb/tb_top.sv
